// ----- design/framed_packet_receiver_core_macros.svh -----
// Assertion macros shared by the frame receiver modules.
// Each use expands to a labelled concurrent assertion on clk, held off in reset.
`ifndef FRAMED_PACKET_RECEIVER_CORE_MACROS_SVH
`define FRAMED_PACKET_RECEIVER_CORE_MACROS_SVH

// Same-cycle implication
`define FRP_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("frame receiver check failed");

// Next-cycle implication
`define FRP_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("frame receiver check failed");

`endif

// ----- design/frp_pkg.sv -----
package frp_pkg;

  // Frame limits
  localparam int MAX_PAYLOAD  = 16;
  localparam int LEN_W        = $clog2(MAX_PAYLOAD + 1);
  localparam int ODO_LEN      = 4;
  localparam int IMU_LEN      = 12;
  // Only the bytes that reach a result are kept
  localparam int STORE_DEPTH  = IMU_LEN;
  localparam int STORE_IDX_W  = $clog2(STORE_DEPTH);
  localparam int NUM_VALUES   = 6;
  localparam int ODO_VALUES   = 2;
  localparam int CNT_W        = 32;
  localparam logic [7:0] MAX_LEN_BYTE = 8'(MAX_PAYLOAD);

  // Parser phase, one-hot
  typedef enum logic [5:0] {
    PH_HDR1 = 6'b000001,
    PH_HDR2 = 6'b000010,
    PH_CMD  = 6'b000100,
    PH_LEN  = 6'b001000,
    PH_DATA = 6'b010000,
    PH_CSUM = 6'b100000
  } phase_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ODO       = 3'd0,
    ST_IMU       = 3'd1,
    ST_CKSUM     = 3'd2,
    ST_UNKNOWN   = 3'd3,
    ST_WRONG_LEN = 3'd4
  } status_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_HEADER_FIRST  = 2'd0,
    REG_HEADER_SECOND = 2'd1,
    REG_ODOMETRY_CODE = 2'd2,
    REG_INERTIAL_CODE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] odometry_code;
    logic [7:0] inertial_code;
  } cfg_t;

  // Result offered by the parser for the byte in the input register
  typedef struct packed {
    logic                             emit;
    status_t                          status;
    logic [NUM_VALUES-1:0][15:0]      values;
    logic [CNT_W-1:0]                 packets_seen;
    logic [CNT_W-1:0]                 bad_checksums;
    logic [CNT_W-1:0]                 unrecognised_cmds;
  } result_t;

endpackage

// ----- design/frp_parser.sv -----
`include "framed_packet_receiver_core_macros.svh"

module frp_parser import frp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       step,
  input  logic [7:0] byte_in,
  output result_t    res
);

  phase_t                   phase, phase_next;
  logic [7:0]               cmd, cmd_next;
  logic [LEN_W-1:0]         len, len_next;
  logic [LEN_W-1:0]         count, count_next;
  logic [7:0]               xsum, xsum_next;
  logic [CNT_W-1:0]         seen_cnt, seen_cnt_next;
  logic [CNT_W-1:0]         cksum_cnt, cksum_cnt_next;
  logic [CNT_W-1:0]         unk_cnt, unk_cnt_next;
  logic [7:0]               store [STORE_DEPTH];
  status_t                  status_next;
  logic [NUM_VALUES-1:0]    value_en;

  // Phase sequencing and running checksum
  always_comb begin
    phase_next     = phase;
    cmd_next       = cmd;
    len_next       = len;
    count_next     = count;
    xsum_next      = xsum;
    unique case (phase)
      PH_HDR1: begin
        if (byte_in == cfg.header_first) phase_next = PH_HDR2;
      end
      PH_HDR2: begin
        if (byte_in == cfg.header_second) phase_next = PH_CMD;
        else if (byte_in == cfg.header_first) phase_next = PH_HDR2;
        else phase_next = PH_HDR1;
      end
      PH_CMD: begin
        cmd_next   = byte_in;
        xsum_next  = byte_in;
        phase_next = PH_LEN;
      end
      PH_LEN: begin
        len_next   = byte_in[LEN_W-1:0];
        xsum_next  = xsum ^ byte_in;
        count_next = '0;
        if (byte_in > MAX_LEN_BYTE) phase_next = PH_HDR1;
        else if (byte_in == 8'd0) phase_next = PH_CSUM;
        else phase_next = PH_DATA;
      end
      PH_DATA: begin
        count_next = count + LEN_W'(1);
        xsum_next  = xsum ^ byte_in;
        if (count_next >= len) phase_next = PH_CSUM;
      end
      PH_CSUM: begin
        phase_next = PH_HDR1;
      end
      default: phase_next = PH_HDR1;
    endcase
  end

  // Checksum byte: classify the frame and bump the counters
  always_comb begin
    seen_cnt_next  = seen_cnt + CNT_W'(1);
    cksum_cnt_next = cksum_cnt;
    unk_cnt_next   = unk_cnt;
    value_en       = '0;
    priority if (xsum != byte_in) begin
      status_next    = ST_CKSUM;
      cksum_cnt_next = cksum_cnt + CNT_W'(1);
    end else if (cmd == cfg.odometry_code) begin
      if (count == LEN_W'(ODO_LEN)) begin
        status_next = ST_ODO;
        value_en    = NUM_VALUES'((1 << ODO_VALUES) - 1);
      end else begin
        status_next = ST_WRONG_LEN;
      end
    end else if (cmd == cfg.inertial_code) begin
      if (count == LEN_W'(IMU_LEN)) begin
        status_next = ST_IMU;
        value_en    = '1;
      end else begin
        status_next = ST_WRONG_LEN;
      end
    end else begin
      status_next  = ST_UNKNOWN;
      unk_cnt_next = unk_cnt + CNT_W'(1);
    end
  end

  // Little-endian words from the stored payload
  always_comb begin
    res.emit              = (phase == PH_CSUM);
    res.status            = status_next;
    res.packets_seen      = seen_cnt_next;
    res.bad_checksums     = cksum_cnt_next;
    res.unrecognised_cmds = unk_cnt_next;
    for (int j = 0; j < NUM_VALUES; j++) begin
      res.values[j] = value_en[j] ? {store[2*j+1], store[2*j]} : 16'd0;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HDR1;
      cmd       <= '0;
      len       <= '0;
      count     <= '0;
      xsum      <= '0;
      seen_cnt  <= '0;
      cksum_cnt <= '0;
      unk_cnt   <= '0;
    end else if (step) begin
      phase <= phase_next;
      cmd   <= cmd_next;
      len   <= len_next;
      count <= count_next;
      xsum  <= xsum_next;
      if (phase == PH_CSUM) begin
        seen_cnt  <= seen_cnt_next;
        cksum_cnt <= cksum_cnt_next;
        unk_cnt   <= unk_cnt_next;
      end
    end
  end

  // Payload bytes, no reset: only entries written in this frame are read
  always_ff @(posedge clk) begin
    if (step && phase == PH_DATA && count < LEN_W'(STORE_DEPTH)) begin
      store[count[STORE_IDX_W-1:0]] <= byte_in;
    end
  end

  `FRP_ASSERT_NEXT(a_cksum_counts, step && res.emit && res.status == ST_CKSUM, cksum_cnt == $past(cksum_cnt) + 32'd1)
  `FRP_ASSERT_NOW(a_data_in_range, phase == PH_DATA, (len != '0) && (count < len))
  `FRP_ASSERT_NEXT(a_long_len_rehunts, step && phase == PH_LEN && byte_in > MAX_LEN_BYTE, phase == PH_HDR1)

endmodule

// ----- design/framed_packet_receiver_core.sv -----
// Framed packet receiver.
// rx channel: one received byte per word (rx_valid/rx_ready/rx_byte).
// out channel: one word per completed frame, carrying status, six signed
// 16-bit values and three wrapping 32-bit counters (out_valid/out_ready).
// cfg port: cfg_we writes cfg_data[7:0] into register cfg_index
// (header bytes and the two command codes); write only while idle.
// Throughput: one byte per cycle when not stalled. A byte is parsed
// while it sits in the input register; the checksum byte's word is
// loaded into the output register when that byte moves on, and
// out_valid rises with it. Other bytes give no word.
// Stall: a finished word waits in the output register while bytes keep
// flowing; rx_ready drops only when the byte in the input register is a
// checksum byte and the output register is still full and not taken.
// Reset (rst, synchronous): header hunt restarts, counters clear, both
// registers empty, configuration returns to 0xAA, 0x55, 0x81, 0x82.
`include "framed_packet_receiver_core_macros.svh"

module framed_packet_receiver_core import frp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  output logic               rx_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic signed [15:0] value_a,
  output logic signed [15:0] value_b,
  output logic signed [15:0] value_c,
  output logic signed [15:0] value_d,
  output logic signed [15:0] value_e,
  output logic signed [15:0] value_f,
  output logic [31:0]        packets_seen,
  output logic [31:0]        bad_checksums,
  output logic [31:0]        unrecognised_cmds,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  cfg_t       cfg;
  logic       in_q_valid;
  logic [7:0] in_q_byte;
  logic       advance;
  result_t    res;
  result_t    out_q;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_first  <= 8'd170;
      cfg.header_second <= 8'd85;
      cfg.odometry_code <= 8'd129;
      cfg.inertial_code <= 8'd130;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_HEADER_FIRST:  cfg.header_first  <= cfg_data;
        REG_HEADER_SECOND: cfg.header_second <= cfg_data;
        REG_ODOMETRY_CODE: cfg.odometry_code <= cfg_data;
        REG_INERTIAL_CODE: cfg.inertial_code <= cfg_data;
        default: ;
      endcase
    end
  end

  // Staged byte moves on unless it makes a word with nowhere to go
  assign advance  = in_q_valid && (!res.emit || !out_valid || out_ready);
  assign rx_ready = !in_q_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (rx_valid && rx_ready) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) in_q_byte <= rx_byte;
  end

  frp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step    (advance),
    .byte_in (in_q_byte),
    .res     (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) out_q <= res;
  end

  assign status            = out_q.status;
  assign value_a           = $signed(out_q.values[0]);
  assign value_b           = $signed(out_q.values[1]);
  assign value_c           = $signed(out_q.values[2]);
  assign value_d           = $signed(out_q.values[3]);
  assign value_e           = $signed(out_q.values[4]);
  assign value_f           = $signed(out_q.values[5]);
  assign packets_seen      = out_q.packets_seen;
  assign bad_checksums     = out_q.bad_checksums;
  assign unrecognised_cmds = out_q.unrecognised_cmds;

  `FRP_ASSERT_NOW(a_stall_cause, !rx_ready, in_q_valid && out_valid && !out_ready)
  `FRP_ASSERT_NOW(a_error_values_zero, out_valid && status != ST_ODO && status != ST_IMU, out_q.values == '0)
  `FRP_ASSERT_NOW(a_odo_upper_zero, out_valid && status == ST_ODO, out_q.values[5:2] == '0)

endmodule

// ----- bench/framed_packet_receiver_core_test.sv -----
`timescale 1ns / 1ps

module framed_packet_receiver_core_test;
  import frp_pkg::*;

  // One result word as it leaves the parser
  typedef struct packed {
    status_t     status;
    logic [15:0] va;
    logic [15:0] vb;
    logic [15:0] vc;
    logic [15:0] vd;
    logic [15:0] ve;
    logic [15:0] vf;
    logic [31:0] seen;
    logic [31:0] bad;
    logic [31:0] unk;
  } frame_result_t;

  // One directed frame: leading bytes, frame body and an optional typed result
  typedef struct packed {
    logic [1:0]    hunt_lead;   // extra first header bytes
    logic          noise_lead;  // junk before the header
    logic [7:0]    cmd;
    logic [7:0]    len;
    logic [127:0]  payload;     // byte i at [8*i +: 8]
    logic [7:0]    csum_xor;    // corrupts the checksum when non-zero
    logic          typed;
    frame_result_t want;
  } stim_row_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               rx_valid = 1'b0;
  logic               rx_ready;
  logic [7:0]         rx_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         status;
  logic signed [15:0] value_a;
  logic signed [15:0] value_b;
  logic signed [15:0] value_c;
  logic signed [15:0] value_d;
  logic signed [15:0] value_e;
  logic signed [15:0] value_f;
  logic [31:0]        packets_seen;
  logic [31:0]        bad_checksums;
  logic [31:0]        unrecognised_cmds;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = REG_HEADER_FIRST;
  logic [7:0]         cfg_data = 8'h00;

  // Parser model state and its own copy of the settings
  cfg_t        cfg_now = '{8'hAA, 8'h55, 8'h81, 8'h82};
  phase_t      rx_phase = PH_HDR1;
  logic [7:0]  frame_cmd = 8'h00;
  logic [7:0]  frame_len = 8'h00;
  logic [7:0]  frame_xor = 8'h00;
  logic [7:0]  frame_bytes [MAX_PAYLOAD];
  int          frame_count = 0;
  logic [31:0] seen_total = '0;
  logic [31:0] bad_total = '0;
  logic [31:0] unknown_total = '0;

  frame_result_t expected_frames [$];
  bit            typed_pending = 1'b0;
  frame_result_t typed_word = '0;

  int mismatches = 0;
  int bytes_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  cfg_t settings [6];

  // Directed frames, all under the reset settings
  stim_row_t dir_rows [13] = '{
    '{2'd0, 1'b0, 8'h81, 8'd4, 128'h7FFF_8000, 8'h00, 1'b1,
      '{ST_ODO, 16'h8000, 16'h7FFF, 16'h0, 16'h0, 16'h0, 16'h0, 32'd1, 32'd0, 32'd0}},
    '{2'd0, 1'b0, 8'h81, 8'd4, 128'h0000_FFFF, 8'h00, 1'b1,
      '{ST_ODO, 16'hFFFF, 16'h0000, 16'h0, 16'h0, 16'h0, 16'h0, 32'd2, 32'd0, 32'd0}},
    '{2'd0, 1'b0, 8'h82, 8'd12, 128'h1234_ABCD_0001_FFFE_5A5A_A5A5, 8'h00, 1'b0, '0},
    '{2'd0, 1'b0, 8'h81, 8'd4, 128'h0, 8'hFF, 1'b1,
      '{ST_CKSUM, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 32'd4, 32'd1, 32'd0}},
    '{2'd0, 1'b0, 8'h00, 8'd0, 128'h0, 8'h00, 1'b1,
      '{ST_UNKNOWN, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 32'd5, 32'd1, 32'd1}},
    '{2'd0, 1'b0, 8'hFF, 8'd16, {16{8'hFF}}, 8'h00, 1'b1,
      '{ST_UNKNOWN, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 32'd6, 32'd1, 32'd2}},
    '{2'd0, 1'b0, 8'h81, 8'd0, 128'h0, 8'h00, 1'b1,
      '{ST_WRONG_LEN, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 32'd7, 32'd1, 32'd2}},
    '{2'd0, 1'b0, 8'h82, 8'd4, 128'h0102_0304, 8'h00, 1'b1,
      '{ST_WRONG_LEN, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 32'd8, 32'd1, 32'd2}},
    '{2'd0, 1'b0, 8'h81, 8'd17, 128'h0, 8'h00, 1'b0, '0},
    '{2'd0, 1'b0, 8'h81, 8'd255, 128'h0, 8'h00, 1'b0, '0},
    '{2'd3, 1'b1, 8'h81, 8'd4, 128'h0102_FEFD, 8'h00, 1'b0, '0},
    '{2'd0, 1'b0, 8'h82, 8'd12, 128'h7FFF_8000_FFFF_0000_7FFF_8000, 8'h00, 1'b0, '0},
    '{2'd0, 1'b0, 8'h81, 8'd0, 128'h0, 8'h80, 1'b1,
      '{ST_CKSUM, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 32'd11, 32'd2, 32'd2}}
  };

  framed_packet_receiver_core u_dut (
    .clk               (clk),
    .rst               (rst),
    .rx_valid          (rx_valid),
    .rx_ready          (rx_ready),
    .rx_byte           (rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .value_a           (value_a),
    .value_b           (value_b),
    .value_c           (value_c),
    .value_d           (value_d),
    .value_e           (value_e),
    .value_f           (value_f),
    .packets_seen      (packets_seen),
    .bad_checksums     (bad_checksums),
    .unrecognised_cmds (unrecognised_cmds),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

  // Advance the parser model by one byte; queue a word on the checksum byte
  task automatic parse_byte(input logic [7:0] b);
    frame_result_t r;
    logic [15:0]   vals [6];
    int            npairs;
    npairs = 0;
    case (rx_phase)
      PH_HDR1: if (b == cfg_now.header_first) rx_phase = PH_HDR2;
      PH_HDR2: begin
        if (b == cfg_now.header_second) rx_phase = PH_CMD;
        else if (b == cfg_now.header_first) rx_phase = PH_HDR2;
        else rx_phase = PH_HDR1;
      end
      PH_CMD: begin
        frame_cmd = b;
        frame_xor = b;
        rx_phase = PH_LEN;
      end
      PH_LEN: begin
        frame_len = b;
        frame_xor ^= b;
        frame_count = 0;
        if (b > MAX_LEN_BYTE) rx_phase = PH_HDR1;
        else if (b == 8'd0) rx_phase = PH_CSUM;
        else rx_phase = PH_DATA;
      end
      PH_DATA: begin
        if (frame_count < MAX_PAYLOAD) frame_bytes[frame_count] = b;
        frame_count++;
        frame_xor ^= b;
        if (frame_count >= frame_len) rx_phase = PH_CSUM;
      end
      PH_CSUM: begin
        r = '0;
        seen_total++;
        if (frame_xor != b) begin
          bad_total++;
          r.status = ST_CKSUM;
        end else if (frame_cmd == cfg_now.odometry_code) begin
          if (frame_count == ODO_LEN) begin
            r.status = ST_ODO;
            npairs = ODO_VALUES;
          end else begin
            r.status = ST_WRONG_LEN;
          end
        end else if (frame_cmd == cfg_now.inertial_code) begin
          if (frame_count == IMU_LEN) begin
            r.status = ST_IMU;
            npairs = NUM_VALUES;
          end else begin
            r.status = ST_WRONG_LEN;
          end
        end else begin
          unknown_total++;
          r.status = ST_UNKNOWN;
        end
        // little-endian pairs, unfilled values stay zero
        for (int j = 0; j < 6; j++)
          vals[j] = (j < npairs) ? {frame_bytes[2*j+1], frame_bytes[2*j]} : 16'h0;
        r.va = vals[0];
        r.vb = vals[1];
        r.vc = vals[2];
        r.vd = vals[3];
        r.ve = vals[4];
        r.vf = vals[5];
        r.seen = seen_total;
        r.bad = bad_total;
        r.unk = unknown_total;
        rx_phase = PH_HDR1;
        if (typed_pending) begin
          r = typed_word;
          typed_pending = 1'b0;
        end
        expected_frames.insert(expected_frames.size(), r);
      end
      default: rx_phase = PH_HDR1;
    endcase
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_word();
    frame_result_t w;
    if (expected_frames.size() == 0) begin
      $error("word with nothing expected: status %0d", status);
      mismatches++;
      return;
    end
    w = expected_frames.pop_front();
    compare_field("status", w.status, status);
    compare_field("value_a", w.va, $unsigned(value_a));
    compare_field("value_b", w.vb, $unsigned(value_b));
    compare_field("value_c", w.vc, $unsigned(value_c));
    compare_field("value_d", w.vd, $unsigned(value_d));
    compare_field("value_e", w.ve, $unsigned(value_e));
    compare_field("value_f", w.vf, $unsigned(value_f));
    compare_field("packets_seen", w.seen, packets_seen);
    compare_field("bad_checksums", w.bad, bad_checksums);
    compare_field("unrecognised_cmds", w.unk, unrecognised_cmds);
  endtask

  // Monitors: both channels sampled at the edge that accepts a word
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_word();
    if (!rst && rx_valid && rx_ready) parse_byte(rx_byte);
  end

  // Result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      rx_valid <= 1'b0;
      @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!rx_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input int hunt_lead, input bit noise_lead,
                            input logic [7:0] cmd, input logic [7:0] len,
                            input logic [127:0] payload, input logic [7:0] csum_xor,
                            input bit use_typed, input frame_result_t typed);
    logic [7:0] sum;
    logic [7:0] filler;
    // junk that matches neither header byte, with a false start in between
    if (noise_lead) begin
      filler = 8'h00;
      while (filler == cfg_now.header_first || filler == cfg_now.header_second) filler++;
      send_byte(filler);
      send_byte(cfg_now.header_first);
      send_byte(filler);
    end
    repeat (hunt_lead) send_byte(cfg_now.header_first);
    send_byte(cfg_now.header_first);
    send_byte(cfg_now.header_second);
    send_byte(cmd);
    send_byte(len);
    sum = cmd ^ len;
    // an over-long length ends the frame at the length byte
    if (len <= MAX_PAYLOAD) begin
      for (int i = 0; i < len; i++) begin
        send_byte(payload[8*i +: 8]);
        sum ^= payload[8*i +: 8];
      end
      typed_pending = use_typed;
      typed_word = typed;
      send_byte(sum ^ csum_xor);
    end
  endtask

  // Mostly well-formed frames with random content, some noise and breakage
  task automatic random_frame();
    int           kind;
    int           lead;
    bit           noisy;
    logic [7:0]   cmd;
    logic [7:0]   len;
    logic [7:0]   fuzz;
    logic [127:0] body;
    kind = $urandom_range(0, 99);
    lead = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
    noisy = ($urandom_range(0, 15) == 0);
    body = {$urandom, $urandom, $urandom, $urandom};
    fuzz = 8'h00;
    cmd = cfg_now.odometry_code;
    len = 8'(ODO_LEN);
    if (kind >= 94) begin
      // truncated frame: later bytes get swallowed as payload
      send_byte(cfg_now.header_first);
      send_byte(cfg_now.header_second);
      send_byte(cmd);
      send_byte(len);
      repeat ($urandom_range(0, ODO_LEN - 1)) send_byte(8'($urandom_range(0, 255)));
      return;
    end else if (kind >= 88) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      return;
    end else if (kind >= 82) begin
      cmd = 8'($urandom_range(0, 255));
      len = 8'($urandom_range(MAX_PAYLOAD + 1, 255));
    end else if (kind >= 72) begin
      if ($urandom_range(0, 1) == 1) begin
        cmd = cfg_now.inertial_code;
        len = 8'(IMU_LEN);
      end
      fuzz = 8'($urandom_range(1, 255));
    end else if (kind >= 62) begin
      cmd = ($urandom_range(0, 1) == 1) ? cfg_now.inertial_code : cfg_now.odometry_code;
      len = 8'($urandom_range(0, MAX_PAYLOAD));
    end else if (kind >= 50) begin
      cmd = 8'($urandom_range(0, 255));
      len = 8'($urandom_range(0, MAX_PAYLOAD));
    end else if (kind >= 28) begin
      cmd = cfg_now.inertial_code;
      len = 8'(IMU_LEN);
    end
    send_frame(lead, noisy, cmd, len, body, fuzz, 1'b0, '0);
  endtask

  // Wait for every expected word plus the pipeline's own latency
  task automatic settle();
    rx_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input cfg_t c);
    write_reg(REG_HEADER_FIRST, c.header_first);
    write_reg(REG_HEADER_SECOND, c.header_second);
    write_reg(REG_ODOMETRY_CODE, c.odometry_code);
    write_reg(REG_INERTIAL_CODE, c.inertial_code);
    cfg_we <= 1'b0;
    cfg_now = c;
  endtask

  initial begin
    int  phase_end;
    logic [7:0] code;
    settings[0] = '{8'hAA, 8'h55, 8'h81, 8'h82};
    settings[1] = '{8'h00, 8'h00, 8'h00, 8'hFF};
    settings[2] = '{8'hFF, 8'hFF, 8'hFF, 8'h00};
    settings[3] = '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
    code = 8'($urandom_range(0, 255));
    settings[4] = '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), code, code};
    settings[5] = '{8'h01, 8'hFE, 8'h7E, 8'h80};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed frames under the reset settings, no idling
    foreach (dir_rows[i])
      send_frame(dir_rows[i].hunt_lead, dir_rows[i].noise_lead, dir_rows[i].cmd,
                 dir_rows[i].len, dir_rows[i].payload, dir_rows[i].csum_xor,
                 dir_rows[i].typed, dir_rows[i].want);
    settle();

    // random phases, each with its own settings and one of four idling mixes
    bytes_sent = 0;
    for (int p = 0; p < 6; p++) begin
      load_settings(settings[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      phase_end = (p + 1) * 325;
      while (bytes_sent < phase_end) random_frame();
      settle();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/frp_pkg.sv
design/frp_parser.sv
design/framed_packet_receiver_core.sv
bench/framed_packet_receiver_core_test.sv
